@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the parse engine modules.
// Each use expands to one labelled concurrent assertion on aclk, off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LRPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lrpe_pkg.sv @@
package lrpe_pkg;

    // Default sizes
    localparam int STACK_SLOTS_DEF    = 256;
    localparam int STATE_COUNT_DEF    = 1024;
    localparam int ACTION_ENTRIES_DEF = 4096;
    localparam int GOTO_ENTRIES_DEF   = 4096;
    localparam int RULE_COUNT_DEF     = 1024;
    localparam int RECOVER_SLOTS_DEF  = 8;

    // Input opcodes
    localparam logic [2:0] OP_STATE   = 3'd0;
    localparam logic [2:0] OP_ACTION  = 3'd1;
    localparam logic [2:0] OP_GOTO    = 3'd2;
    localparam logic [2:0] OP_RULE    = 3'd3;
    localparam logic [2:0] OP_RECOVER = 3'd4;
    localparam logic [2:0] OP_START   = 3'd5;
    localparam logic [2:0] OP_TOKEN   = 3'd6;
    localparam logic [2:0] OP_NONE    = 3'd7;

    // Result events
    localparam logic [2:0] EV_SHIFT   = 3'd0;
    localparam logic [2:0] EV_REDUCE  = 3'd1;
    localparam logic [2:0] EV_ACCEPT  = 3'd2;
    localparam logic [2:0] EV_ERROR   = 3'd3;
    localparam logic [2:0] EV_DROP    = 3'd4;
    localparam logic [2:0] EV_ABORT   = 3'd5;
    localparam logic [2:0] EV_LOADED  = 3'd6;
    localparam logic [2:0] EV_RSHIFT  = 3'd7;

    // Parse status
    localparam logic [1:0] PS_IDLE     = 2'd0;
    localparam logic [1:0] PS_RUN      = 2'd1;
    localparam logic [1:0] PS_ACCEPTED = 2'd2;
    localparam logic [1:0] PS_ABORTED  = 2'd3;

    // Result value source
    localparam logic [1:0] VS_ZERO = 2'd0;
    localparam logic [1:0] VS_CS   = 2'd1;
    localparam logic [1:0] VS_RULE = 2'd2;
    localparam logic [1:0] VS_TOK  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_RECOVER_USED = 1'b0;
    localparam logic CFG_CONTINUE     = 1'b1;

    localparam logic [31:0] ACCEPT_CODE   = 32'h7FFF_FFFF;
    localparam logic [10:0] GOTO_SENTINEL = 11'h7FF;
    localparam logic [1:0]  RESTART_COUNT = 2'd3;
    localparam logic [6:0]  EVENT_BUDGET  = 7'd62;
    localparam int          APOS_W        = 13;

    typedef struct packed {
        logic [31:0] dflt;
        logic [7:0]  count;
        logic [11:0] first;
    } st_entry_t;

    typedef struct packed {
        logic [31:0] val;
        logic [9:0]  sym;
    } act_entry_t;

    typedef struct packed {
        logic [9:0]  dest;
        logic [10:0] origin;
    } goto_entry_t;

    typedef struct packed {
        logic [7:0]  len;
        logic [11:0] first;
    } rule_entry_t;

    typedef struct packed {
        logic       take_item;
        logic       load_write;
        logic       start_init;
        logic       set_status;
        logic [1:0] status_code;
        logic       lk_sym_tok;
        logic       lk_sym_rec;
        logic       st_rd;
        logic       lk_load;
        logic       lk_zero;
        logic       act_rd;
        logic       lk_hit;
        logic       act_adv;
        logic       push;
        logic       push_goto;
        logic       cd_dec;
        logic       cd_set3;
        logic       err_inc;
        logic       rule_latch;
        logic       rule_rd;
        logic       red_pop;
        logic       stk_rd;
        logic       stk_rd_prev;
        logic       goto_rd;
        logic       gpos_inc;
        logic       pop_take;
        logic       ri_clear;
        logic       ri_inc;
        logic       rec_rd;
        logic       n_clear;
        logic       emit;
        logic [2:0] ev;
        logic [1:0] vsel;
    } lrpe_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       running;
        logic       st_oob;
        logic       act_done;
        logic       act_match;
        logic       val_accept;
        logic       val_pos;
        logic       val_neg;
        logic       stack_full;
        logic       sp_zero;
        logic       rule_bad;
        logic       len_bad;
        logic       goto_oob;
        logic       goto_hit;
        logic       cd_is3;
        logic       cd_is0;
        logic       tok_zero;
        logic       cont;
        logic       ri_done;
        logic       budget_out;
        logic       out_free;
    } lrpe_stat_t;

    // Events that close the item's result run
    function automatic logic ev_is_last(input logic [2:0] ev);
        case (ev) inside
            EV_SHIFT, EV_ACCEPT, EV_DROP, EV_ABORT, EV_LOADED: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

endpackage

@@ hw/rtl/lrpe_ctrl.sv @@
`include "assert_macros.svh"

module lrpe_ctrl
    import lrpe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  lrpe_stat_t stat,
    output lrpe_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_EMIT     = 5'd2;
    localparam logic [4:0] S_TOP      = 5'd3;
    localparam logic [4:0] S_LK_ST    = 5'd4;
    localparam logic [4:0] S_LK_WAIT  = 5'd5;
    localparam logic [4:0] S_LK_ACT   = 5'd6;
    localparam logic [4:0] S_LK_CMP   = 5'd7;
    localparam logic [4:0] S_DISP     = 5'd8;
    localparam logic [4:0] S_RED      = 5'd9;
    localparam logic [4:0] S_RED_WAIT = 5'd10;
    localparam logic [4:0] S_RED_STK  = 5'd11;
    localparam logic [4:0] S_GT       = 5'd12;
    localparam logic [4:0] S_GT_CMP   = 5'd13;
    localparam logic [4:0] S_REC      = 5'd14;
    localparam logic [4:0] S_ABORT    = 5'd15;
    localparam logic [4:0] S_REC_INIT = 5'd16;
    localparam logic [4:0] S_REC_TRY  = 5'd17;
    localparam logic [4:0] S_REC_SYM  = 5'd18;
    localparam logic [4:0] S_REC_POP  = 5'd19;
    localparam logic [4:0] S_REC_RES  = 5'd20;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;
    logic       ctx_reg, ctx_next;     // 1: lookup belongs to recovery
    logic [2:0] ev_reg, ev_next;
    logic [1:0] vsel_reg, vsel_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            ctx_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ctx_reg   <= ctx_next;
        end
        ev_reg   <= ev_next;
        vsel_reg <= vsel_next;
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        ctx_next   = ctx_reg;
        ev_next    = ev_reg;
        vsel_next  = vsel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (stat.op) inside
                    OP_STATE, OP_ACTION, OP_GOTO, OP_RULE, OP_RECOVER: begin
                        cmd.load_write = 1'b1;
                        ev_next    = EV_LOADED;
                        vsel_next  = VS_ZERO;
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                    OP_START: begin
                        cmd.start_init = 1'b1;
                        ev_next    = EV_LOADED;
                        vsel_next  = VS_ZERO;
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                    OP_TOKEN: begin
                        cmd.n_clear = 1'b1;
                        state_next  = stat.running ? S_TOP : S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.ev     = ev_reg;
                    cmd.vsel   = vsel_reg;
                    state_next = ret_reg;
                end
            end
            S_TOP: begin
                if (stat.budget_out) begin
                    state_next = S_ABORT;
                end else begin
                    cmd.lk_sym_tok = 1'b1;
                    ctx_next   = 1'b0;
                    state_next = S_LK_ST;
                end
            end
            S_LK_ST: begin
                cmd.st_rd  = 1'b1;
                state_next = S_LK_WAIT;
            end
            S_LK_WAIT: begin
                if (stat.st_oob) begin
                    cmd.lk_zero = 1'b1;
                    state_next  = S_DISP;
                end else begin
                    cmd.lk_load = 1'b1;
                    state_next  = S_LK_ACT;
                end
            end
            S_LK_ACT: begin
                if (stat.act_done) begin
                    state_next = S_DISP;
                end else begin
                    cmd.act_rd = 1'b1;
                    state_next = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                if (stat.act_match) begin
                    cmd.lk_hit = 1'b1;
                    state_next = S_DISP;
                end else begin
                    cmd.act_adv = 1'b1;
                    state_next  = S_LK_ACT;
                end
            end
            S_DISP: begin
                if (ctx_reg) begin
                    state_next = S_REC_RES;
                end else if (stat.val_accept) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = PS_ACCEPTED;
                    ev_next    = EV_ACCEPT;
                    vsel_next  = VS_ZERO;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end else if (stat.val_pos) begin
                    if (stat.stack_full) begin
                        state_next = S_ABORT;
                    end else begin
                        cmd.push   = 1'b1;
                        cmd.cd_dec = 1'b1;
                        ev_next    = EV_SHIFT;
                        vsel_next  = VS_CS;
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                end else if (stat.val_neg) begin
                    cmd.rule_latch = 1'b1;
                    state_next     = S_RED;
                end else begin
                    state_next = S_REC;
                end
            end
            S_RED: begin
                if (stat.rule_bad) begin
                    state_next = S_ABORT;
                end else begin
                    cmd.rule_rd = 1'b1;
                    state_next  = S_RED_WAIT;
                end
            end
            S_RED_WAIT: begin
                if (stat.len_bad) begin
                    state_next = S_ABORT;
                end else begin
                    cmd.red_pop = 1'b1;
                    state_next  = S_RED_STK;
                end
            end
            S_RED_STK: begin
                cmd.stk_rd = 1'b1;
                state_next = S_GT;
            end
            S_GT: begin
                if (stat.goto_oob) begin
                    state_next = S_ABORT;
                end else begin
                    cmd.goto_rd = 1'b1;
                    state_next  = S_GT_CMP;
                end
            end
            S_GT_CMP: begin
                if (!stat.goto_hit) begin
                    cmd.gpos_inc = 1'b1;
                    state_next   = S_GT;
                end else if (stat.stack_full) begin
                    state_next = S_ABORT;
                end else begin
                    cmd.push      = 1'b1;
                    cmd.push_goto = 1'b1;
                    ev_next    = EV_REDUCE;
                    vsel_next  = VS_RULE;
                    ret_next   = S_TOP;
                    state_next = S_EMIT;
                end
            end
            S_REC: begin
                if (stat.cd_is3) begin
                    if (stat.tok_zero) begin
                        state_next = S_ABORT;
                    end else begin
                        ev_next    = EV_DROP;
                        vsel_next  = VS_TOK;
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                end else if (stat.cd_is0) begin
                    cmd.err_inc = 1'b1;
                    ev_next    = EV_ERROR;
                    vsel_next  = VS_CS;
                    ret_next   = stat.cont ? S_REC_INIT : S_ABORT;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_REC_INIT;
                end
            end
            S_ABORT: begin
                cmd.set_status  = 1'b1;
                cmd.status_code = PS_ABORTED;
                ev_next    = EV_ABORT;
                vsel_next  = VS_ZERO;
                ret_next   = S_IDLE;
                state_next = S_EMIT;
            end
            S_REC_INIT: begin
                cmd.cd_set3  = 1'b1;
                cmd.ri_clear = 1'b1;
                state_next   = S_REC_TRY;
            end
            S_REC_TRY: begin
                if (!stat.ri_done) begin
                    cmd.rec_rd = 1'b1;
                    state_next = S_REC_SYM;
                end else if (stat.sp_zero) begin
                    state_next = S_ABORT;
                end else begin
                    cmd.stk_rd      = 1'b1;
                    cmd.stk_rd_prev = 1'b1;
                    state_next      = S_REC_POP;
                end
            end
            S_REC_SYM: begin
                cmd.lk_sym_rec = 1'b1;
                ctx_next   = 1'b1;
                state_next = S_LK_ST;
            end
            S_REC_POP: begin
                cmd.pop_take = 1'b1;
                cmd.ri_clear = 1'b1;
                state_next   = S_REC_TRY;
            end
            S_REC_RES: begin
                if (!stat.val_pos) begin
                    cmd.ri_inc = 1'b1;
                    state_next = S_REC_TRY;
                end else if (stat.stack_full) begin
                    state_next = S_ABORT;
                end else begin
                    cmd.push   = 1'b1;
                    ev_next    = EV_RSHIFT;
                    vsel_next  = VS_CS;
                    ret_next   = S_TOP;
                    state_next = S_EMIT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `LRPE_ASSERT_NEXT(a_last_to_idle,
        (state_reg == S_EMIT) && stat.out_free && ev_is_last(ev_reg),
        state_reg == S_IDLE, "closing result did not return to idle")
    `LRPE_ASSERT_NOW(a_take_only_idle, cmd.take_item, state_reg == S_IDLE,
        "item taken outside idle")

endmodule

@@ hw/rtl/lrpe_datapath.sv @@
`include "assert_macros.svh"

module lrpe_datapath
    import lrpe_pkg::*;
#(
    parameter int STACK_SLOTS    = STACK_SLOTS_DEF,
    parameter int STATE_COUNT    = STATE_COUNT_DEF,
    parameter int ACTION_ENTRIES = ACTION_ENTRIES_DEF,
    parameter int GOTO_ENTRIES   = GOTO_ENTRIES_DEF,
    parameter int RULE_COUNT     = RULE_COUNT_DEF,
    parameter int RECOVER_SLOTS  = RECOVER_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [95:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  lrpe_cmd_t   cmd,
    output lrpe_stat_t  stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int SP_W      = $clog2(STACK_SLOTS);
    localparam int ST_AW     = $clog2(STATE_COUNT);
    localparam int ACT_AW    = $clog2(ACTION_ENTRIES);
    localparam int GOTO_AW   = $clog2(GOTO_ENTRIES);
    localparam int RULE_AW   = $clog2(RULE_COUNT);
    localparam int REC_AW    = (RECOVER_SLOTS > 1) ? $clog2(RECOVER_SLOTS) : 1;
    localparam int RI_W      = $clog2(RECOVER_SLOTS + 1);
    localparam int GPOS_BITS = $clog2(GOTO_ENTRIES + 1);
    localparam int GPOS_W    = (GPOS_BITS > 13) ? GPOS_BITS : 13;

    // Memories
    st_entry_t   st_mem   [STATE_COUNT];
    act_entry_t  act_mem  [ACTION_ENTRIES];
    goto_entry_t goto_mem [GOTO_ENTRIES];
    rule_entry_t rule_mem [RULE_COUNT];
    logic [9:0]  rec_mem  [RECOVER_SLOTS];
    logic [9:0]  stack_mem[STACK_SLOTS];

    st_entry_t   st_rd_reg;
    act_entry_t  act_rd_reg;
    goto_entry_t goto_rd_reg;
    rule_entry_t rule_rd_reg;
    logic [9:0]  rec_rd_reg;
    logic [9:0]  stk_rd_reg;

    // Latched item
    logic [2:0]  op_reg;
    logic [11:0] idx_reg;
    logic [9:0]  tok_reg;
    logic [31:0] aval_reg;
    logic [11:0] first_reg;
    logic [7:0]  count_reg;
    logic [10:0] origin_reg;
    logic [9:0]  dest_reg;

    // Parser state
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [9:0]        cs_reg, cs_next;
    logic [1:0]        cd_reg, cd_next;
    logic [15:0]       err_reg, err_next;
    logic [1:0]        pstat_reg, pstat_next;
    logic [6:0]        n_reg, n_next;
    logic [3:0]        rtu_reg;
    logic              cont_reg;

    // Search state
    logic [9:0]        lk_sym_reg;
    logic [31:0]       lk_val_reg;
    logic [APOS_W-1:0] apos_reg;
    logic [7:0]        acnt_reg;
    logic [31:0]       rule_reg;
    logic [GPOS_W-1:0] gpos_reg;
    logic [RI_W-1:0]   ri_reg;

    // Output register
    logic        m_valid_reg;
    logic [2:0]  m_ev_reg;
    logic [9:0]  m_val_reg;
    logic [7:0]  m_depth_reg;
    logic [15:0] m_err_reg;
    logic        m_last_reg;

    logic [31:0] idx_w, cs_w, apos_w, gpos_w, ri_w, sp_w, sp_inc_w, sp_dec_w, sp_red_w;
    logic [9:0]  push_val;
    logic [9:0]  emit_val;
    logic        out_free;

    assign idx_w    = 32'(idx_reg);
    assign cs_w     = 32'(cs_reg);
    assign apos_w   = 32'(apos_reg);
    assign gpos_w   = 32'(gpos_reg);
    assign ri_w     = 32'(ri_reg);
    assign sp_w     = 32'(sp_reg);
    assign sp_inc_w = sp_w + 32'd1;
    assign sp_dec_w = sp_w - 32'd1;
    assign sp_red_w = sp_w - 32'(rule_rd_reg.len);
    assign push_val = cmd.push_goto ? goto_rd_reg.dest : lk_val_reg[9:0];
    assign out_free = !m_valid_reg || m_tready;

    // Item latch, table loads and table reads
    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            op_reg     <= s_tuser;
            idx_reg    <= s_tdata[11:0];
            tok_reg    <= s_tdata[21:12];
            aval_reg   <= s_tdata[53:22];
            first_reg  <= s_tdata[65:54];
            count_reg  <= s_tdata[73:66];
            origin_reg <= s_tdata[84:74];
            dest_reg   <= s_tdata[94:85];
        end
        if (cmd.load_write) begin
            unique case (op_reg)
                OP_STATE: begin
                    if (idx_w < STATE_COUNT) begin
                        st_mem[idx_w[ST_AW-1:0]] <= '{dflt: aval_reg, count: count_reg,
                                                      first: first_reg};
                    end
                end
                OP_ACTION: begin
                    if (idx_w < ACTION_ENTRIES) begin
                        act_mem[idx_w[ACT_AW-1:0]] <= '{val: aval_reg, sym: tok_reg};
                    end
                end
                OP_GOTO: begin
                    if (idx_w < GOTO_ENTRIES) begin
                        goto_mem[idx_w[GOTO_AW-1:0]] <= '{dest: dest_reg, origin: origin_reg};
                    end
                end
                OP_RULE: begin
                    if (idx_w < RULE_COUNT) begin
                        rule_mem[idx_w[RULE_AW-1:0]] <= '{len: count_reg, first: first_reg};
                    end
                end
                default: begin
                    if (idx_w < RECOVER_SLOTS) begin
                        rec_mem[idx_w[REC_AW-1:0]] <= tok_reg;
                    end
                end
            endcase
        end
        if (cmd.st_rd) begin
            st_rd_reg <= st_mem[cs_w[ST_AW-1:0]];
        end
        if (cmd.act_rd) begin
            act_rd_reg <= act_mem[apos_w[ACT_AW-1:0]];
        end
        if (cmd.goto_rd) begin
            goto_rd_reg <= goto_mem[gpos_w[GOTO_AW-1:0]];
        end
        if (cmd.rule_rd) begin
            rule_rd_reg <= rule_mem[rule_reg[RULE_AW-1:0]];
        end
        if (cmd.rec_rd) begin
            rec_rd_reg <= rec_mem[ri_w[REC_AW-1:0]];
        end
    end

    // State stack: one write, one read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.start_init) begin
            stack_mem[0] <= '0;
        end else if (cmd.push) begin
            stack_mem[sp_inc_w[SP_W-1:0]] <= push_val;
        end
        if (cmd.stk_rd) begin
            stk_rd_reg <= stack_mem[cmd.stk_rd_prev ? sp_dec_w[SP_W-1:0] : sp_reg];
        end
    end

    // Search registers
    always_ff @(posedge aclk) begin
        if (cmd.lk_sym_tok) begin
            lk_sym_reg <= tok_reg;
        end else if (cmd.lk_sym_rec) begin
            lk_sym_reg <= rec_rd_reg;
        end
        if (cmd.lk_zero) begin
            lk_val_reg <= '0;
        end else if (cmd.lk_load) begin
            lk_val_reg <= st_rd_reg.dflt;
        end else if (cmd.lk_hit) begin
            lk_val_reg <= act_rd_reg.val;
        end
        if (cmd.lk_load) begin
            apos_reg <= APOS_W'(st_rd_reg.first);
            acnt_reg <= st_rd_reg.count;
        end else if (cmd.act_adv) begin
            apos_reg <= apos_reg + APOS_W'(1);
            acnt_reg <= acnt_reg - 8'd1;
        end
        if (cmd.rule_latch) begin
            rule_reg <= 32'd0 - lk_val_reg;
        end
        if (cmd.red_pop) begin
            gpos_reg <= GPOS_W'(rule_rd_reg.first);
        end else if (cmd.gpos_inc) begin
            gpos_reg <= gpos_reg + GPOS_W'(1);
        end
        if (cmd.ri_clear) begin
            ri_reg <= '0;
        end else if (cmd.ri_inc) begin
            ri_reg <= ri_reg + RI_W'(1);
        end
    end

    always_comb begin
        sp_next    = sp_reg;
        cs_next    = cs_reg;
        cd_next    = cd_reg;
        err_next   = err_reg;
        pstat_next = pstat_reg;
        n_next     = n_reg;
        if (cmd.start_init) begin
            sp_next    = '0;
            cs_next    = '0;
            cd_next    = '0;
            err_next   = '0;
            pstat_next = PS_RUN;
        end
        if (cmd.push) begin
            sp_next = sp_inc_w[SP_W-1:0];
            cs_next = push_val;
        end
        if (cmd.red_pop) begin
            sp_next = sp_red_w[SP_W-1:0];
        end
        if (cmd.pop_take) begin
            sp_next = sp_dec_w[SP_W-1:0];
            cs_next = stk_rd_reg;
        end
        if (cmd.cd_dec && (cd_reg != 2'd0)) begin
            cd_next = cd_reg - 2'd1;
        end
        if (cmd.cd_set3) begin
            cd_next = RESTART_COUNT;
        end
        if (cmd.err_inc && (err_reg != 16'hFFFF)) begin
            err_next = err_reg + 16'd1;
        end
        if (cmd.set_status) begin
            pstat_next = cmd.status_code;
        end
        if (cmd.n_clear) begin
            n_next = '0;
        end else if (cmd.emit) begin
            n_next = n_reg + 7'd1;
        end
    end

    always_comb begin
        case (cmd.vsel)
            VS_CS:   emit_val = cs_reg;
            VS_RULE: emit_val = rule_reg[9:0];
            VS_TOK:  emit_val = tok_reg;
            default: emit_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            cs_reg      <= '0;
            cd_reg      <= '0;
            err_reg     <= '0;
            pstat_reg   <= PS_IDLE;
            n_reg       <= '0;
            rtu_reg     <= '0;
            cont_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            sp_reg    <= sp_next;
            cs_reg    <= cs_next;
            cd_reg    <= cd_next;
            err_reg   <= err_next;
            pstat_reg <= pstat_next;
            n_reg     <= n_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_RECOVER_USED: rtu_reg  <= cfg_data;
                    CFG_CONTINUE:     cont_reg <= cfg_data[0];
                endcase
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.emit) begin
            m_ev_reg    <= cmd.ev;
            m_val_reg   <= emit_val;
            m_depth_reg <= sp_w[7:0];
            m_err_reg   <= err_reg;
            m_last_reg  <= ev_is_last(cmd.ev);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ev_reg;
    assign m_tdata  = {6'd0, m_err_reg, m_depth_reg, m_val_reg};
    assign m_tlast  = m_last_reg;

    always_comb begin
        stat            = '0;
        stat.op         = op_reg;
        stat.running    = (pstat_reg == PS_RUN);
        stat.st_oob     = (cs_w >= STATE_COUNT);
        stat.act_done   = (acnt_reg == 8'd0) || (apos_w >= ACTION_ENTRIES);
        stat.act_match  = (act_rd_reg.sym == lk_sym_reg);
        stat.val_accept = (lk_val_reg == ACCEPT_CODE);
        stat.val_pos    = !lk_val_reg[31] && (lk_val_reg != 32'd0);
        stat.val_neg    = lk_val_reg[31];
        stat.stack_full = (sp_w >= STACK_SLOTS - 1);
        stat.sp_zero    = (sp_reg == '0);
        stat.rule_bad   = (rule_reg >= RULE_COUNT);
        stat.len_bad    = (32'(rule_rd_reg.len) > sp_w);
        stat.goto_oob   = (gpos_w >= GOTO_ENTRIES);
        stat.goto_hit   = (goto_rd_reg.origin == GOTO_SENTINEL) ||
                          (goto_rd_reg.origin == {1'b0, stk_rd_reg});
        stat.cd_is3     = (cd_reg == RESTART_COUNT);
        stat.cd_is0     = (cd_reg == 2'd0);
        stat.tok_zero   = (tok_reg == 10'd0);
        stat.cont       = cont_reg;
        stat.ri_done    = (ri_w >= 32'(rtu_reg)) || (ri_w >= RECOVER_SLOTS);
        stat.budget_out = (n_reg >= EVENT_BUDGET);
        stat.out_free   = out_free;
    end

    `LRPE_ASSERT_NOW(a_emit_room, cmd.emit, out_free, "result issued over a held result")
    `LRPE_ASSERT_NOW(a_push_room, cmd.push, sp_w < STACK_SLOTS - 1, "push on a full stack")
    `LRPE_ASSERT_NEXT(a_err_count, cmd.err_inc, err_reg != 16'd0,
        "error count zero after a report")

endmodule

@@ hw/rtl/lr_parse_engine_core.sv @@
// LR parse engine: a yacc-style table-driven shift-reduce parser. Load the state, action,
// goto, rule and recovery tables through input transactions (each answers one "loaded"
// result), send a start transaction, then one transaction per token; every parse step comes
// back as a result transaction, the last one of a token flagged by m_tlast. One input
// transaction is in work at a time. An action lookup reads the state entry, then compares
// the action entries one by one and falls back to the state default when none matches;
// the state and action tables sit in single-port memories with registered reads. A reduce
// scans the goto entries, and error recovery repeats the lookup for each recovery token
// at each popped stack level. Each result passes through the output register, and a held
// output stalls the engine. Configuration writes are always accepted and belong between
// parses.
module lr_parse_engine_core
    import lrpe_pkg::*;
#(
    parameter int STACK_SLOTS    = STACK_SLOTS_DEF,
    parameter int STATE_COUNT    = STATE_COUNT_DEF,
    parameter int ACTION_ENTRIES = ACTION_ENTRIES_DEF,
    parameter int GOTO_ENTRIES   = GOTO_ENTRIES_DEF,
    parameter int RULE_COUNT     = RULE_COUNT_DEF,
    parameter int RECOVER_SLOTS  = RECOVER_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // table_index, token, action_value, list_start, entry_count, origin_state, dest_state
    input  logic [95:0] s_tdata,
    // opcode
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_value, depth_after, error_count
    output logic [39:0] m_tdata,
    // event_res
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    lrpe_cmd_t  cmd;
    lrpe_stat_t stat;

    // Registers are plain flops: take every write at once
    assign cfg_ready = 1'b1;

    lrpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrpe_datapath #(
        .STACK_SLOTS    (STACK_SLOTS),
        .STATE_COUNT    (STATE_COUNT),
        .ACTION_ENTRIES (ACTION_ENTRIES),
        .GOTO_ENTRIES   (GOTO_ENTRIES),
        .RULE_COUNT     (RULE_COUNT),
        .RECOVER_SLOTS  (RECOVER_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
